@@ rtl/core/mfs_pkg.sv @@
// Package for the multilevel feedback scheduler: sizes, the task cell entry,
// the cell command, the controller state enum and a find-first helper.
// Used by every file of the block; depends on nothing.
package mfs_pkg;

	localparam int MAX_TASKS = 16;
	localparam int LEVELS    = 3;
	localparam int ID_SPACE  = 16;
	localparam int ID_W      = 4;
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int ALLOT_W   = 4;
	localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS - 1);

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_ALLOT  = 2'd0;
	localparam logic [1:0] REG_PERIOD = 2'd1;
	localparam logic [1:0] REG_RUN    = 2'd2;

	// One queued task. Cells hold entries in arrival order; the order of the
	// entries of one level is that level's queue.
	typedef struct packed {
		logic               vld;
		logic [ID_W-1:0]    id;
		logic [LVL_W-1:0]   lvl;
		logic [ALLOT_W-1:0] allot;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_REMOVE,
		CELL_UPDATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] pos;
		entry_t           wdata;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOOST_DEL,
		ST_BOOST_ADD,
		ST_CHARGE,
		ST_DEMOTE_ADD,
		ST_PICK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic            found;
		logic [IDX_W-1:0] idx;
	} find_t;

	typedef struct packed {
		logic            finished;
		logic            boosted;
		logic [ID_W-1:0] run_task;
		logic            run_valid;
		logic [ID_W-1:0] stop_task;
		logic            stop_valid;
		logic            register_ok;
	} result_t;

	// Lowest set bit of a cell vector.
	function automatic find_t first_one(input logic [MAX_TASKS-1:0] v);
		find_t r;
		r.found = |v;
		r.idx   = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (v[i]) r.idx = IDX_W'(i);
		end
		return r;
	endfunction

endpackage

@@ rtl/core/mfs_cell.sv @@
// One cell of the task chain: holds a single queue entry and can load it from
// the command, from its right-hand neighbour, or keep it.
// Depends on mfs_pkg.
module mfs_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mfs_pkg::CNT_W-1:0]    idx,
	input  mfs_pkg::cell_cmd_t           cmd,
	input  mfs_pkg::entry_t              nxt,
	output mfs_pkg::entry_t              ent
);

	mfs_pkg::entry_t ent_q;

	// Each cell decides locally from its own index and the broadcast command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			case (cmd.op)
				mfs_pkg::CELL_APPEND,
				mfs_pkg::CELL_UPDATE: begin
					if (idx == cmd.pos) ent_q <= cmd.wdata;
				end
				mfs_pkg::CELL_REMOVE: begin
					if (idx >= cmd.pos) ent_q <= nxt;
				end
				default: begin
					ent_q <= ent_q;
				end
			endcase
		end
	end

	assign ent = ent_q;

endmodule

@@ rtl/core/mfs_chain.sv @@
// Row of task cells; removal closes the gap by shifting each later entry one
// cell towards the head. Depends on mfs_pkg and mfs_cell.
module mfs_chain (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mfs_pkg::cell_cmd_t                       cmd,
	output mfs_pkg::entry_t [mfs_pkg::MAX_TASKS-1:0] ents
);

	mfs_pkg::entry_t [mfs_pkg::MAX_TASKS:0] link;

	assign link[mfs_pkg::MAX_TASKS] = '0;

	for (genvar g = 0; g < mfs_pkg::MAX_TASKS; g++) begin : g_cell
		mfs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (mfs_pkg::CNT_W'(g)),
			.cmd    (cmd),
			.nxt    (link[g+1]),
			.ent    (link[g])
		);
		assign ents[g] = link[g];
	end

endmodule

@@ rtl/core/multilevel_feedback_scheduler.sv @@
// Three-level feedback queue scheduler: a registration goes straight to its
// result; a tick charges the stopped task and picks the next, with an append
// for a demotion and, for a boost, one removal per low-level task and one to
// finish, then one append step per id. One item is in work at a time: input
// is ready only when idle, after the result is in the output register. Asynchronous
// active-low reset empties the chain and restores the register defaults.
module multilevel_feedback_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [3:0] task_id
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] register_ok, [1] stop_valid, [5:2] stop_task, [6] run_valid,
	// [10:7] run_task, [11] boosted, [12] finished
	output logic [15:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int MT = mfs_pkg::MAX_TASKS;

	mfs_pkg::state_t   state_q, state_n;
	mfs_pkg::cell_cmd_t cmd;
	mfs_pkg::entry_t [MT-1:0] ents;

	logic [3:0]  allot_cfg_q;
	logic [9:0]  period_q;
	logic [15:0] run_q;

	logic [mfs_pkg::ID_SPACE-1:0] present_q, low_mask_q;
	logic [mfs_pkg::CNT_W-1:0]    count_q;
	logic                         cur_vld_q;
	logic [mfs_pkg::ID_W-1:0]     cur_id_q, start_q, prev_q;
	logic                         prev_vld_q;
	logic [4:0]                   iter_q;
	logic [16:0]                  te_q;
	logic [10:0]                  tsb_q;
	logic                         succ_vld_q;
	logic [mfs_pkg::ID_W-1:0]     succ_id_q;
	logic [mfs_pkg::LVL_W-1:0]    succ_lvl_q;
	mfs_pkg::entry_t              dem_q;
	mfs_pkg::result_t             res_q, out_q;
	logic                         out_vld_q;

	mfs_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ents   (ents)
	);

	// Match vectors over the chain.
	logic [MT-1:0] low_vec, prev_vec, succ_vec, head_vec;
	logic [mfs_pkg::LEVELS-1:0] lvl_any;
	mfs_pkg::find_t f_low, f_prev, f_succ, f_head;
	mfs_pkg::entry_t prev_ent, succ_ent, low_ent, head_ent;
	logic [mfs_pkg::LVL_W-1:0] h_lvl;

	always_comb begin
		h_lvl = '0;
		for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
			lvl_any[l] = 1'b0;
			for (int i = 0; i < MT; i++) begin
				if (ents[i].vld && ents[i].lvl == mfs_pkg::LVL_W'(l)) lvl_any[l] = 1'b1;
			end
			if (lvl_any[l]) h_lvl = mfs_pkg::LVL_W'(l);
		end
		for (int i = 0; i < MT; i++) begin
			low_vec[i]  = ents[i].vld && (ents[i].lvl != mfs_pkg::TOP_LVL);
			prev_vec[i] = ents[i].vld && (ents[i].id == prev_q);
			head_vec[i] = ents[i].vld && (ents[i].lvl == h_lvl);
		end
		f_low  = mfs_pkg::first_one(low_vec);
		f_prev = mfs_pkg::first_one(prev_vec);
		f_head = mfs_pkg::first_one(head_vec);
		prev_ent = '0;
		low_ent  = '0;
		head_ent = '0;
		for (int i = 0; i < MT; i++) begin
			if (prev_vec[i]) prev_ent = prev_ent | ents[i];
			if (f_low.idx == mfs_pkg::IDX_W'(i)) low_ent = low_ent | ents[i];
			if (f_head.idx == mfs_pkg::IDX_W'(i)) head_ent = head_ent | ents[i];
		end
		for (int i = 0; i < MT; i++) begin
			succ_vec[i] = ents[i].vld && (ents[i].lvl == prev_ent.lvl)
				&& (mfs_pkg::IDX_W'(i) > f_prev.idx);
		end
		f_succ = mfs_pkg::first_one(succ_vec);
		succ_ent = '0;
		for (int i = 0; i < MT; i++) begin
			if (f_succ.idx == mfs_pkg::IDX_W'(i)) succ_ent = succ_ent | ents[i];
		end
	end

	// Handshake and tick bookkeeping.
	logic        in_xfer, tick, reg_ok, boost_now, demote;
	logic [16:0] te_n;
	logic [10:0] tsb_n;
	logic [3:0]  a_new;
	logic [mfs_pkg::ID_W-1:0] in_id, add_id;
	logic        nxt_vld;
	logic [mfs_pkg::ID_W-1:0] nxt_id;
	logic        fin;

	assign s_tready = (state_q == mfs_pkg::ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign tick     = s_tuser;
	assign in_id    = s_tdata[3:0];
	assign reg_ok   = !present_q[in_id] && (count_q < mfs_pkg::CNT_W'(MT));
	assign te_n     = (te_q == 17'h1FFFF) ? te_q : te_q + 17'd1;
	assign tsb_n    = (tsb_q == 11'h7FF) ? tsb_q : tsb_q + 11'd1;
	assign boost_now = tsb_n >= ({1'b0, period_q} + 11'd1);
	assign a_new    = (prev_ent.allot != 4'd0) ? prev_ent.allot - 4'd1 : 4'd0;
	assign demote   = prev_vld_q && (a_new == 4'd0) && (prev_ent.lvl != '0);
	assign add_id   = start_q + iter_q[3:0];
	assign fin      = te_q > {1'b0, run_q};

	// Final pick on the settled queues.
	always_comb begin
		if (!succ_vld_q) begin
			nxt_vld = |lvl_any;
			nxt_id  = head_ent.id;
		end else if (!(|lvl_any) || succ_lvl_q >= h_lvl) begin
			nxt_vld = 1'b1;
			nxt_id  = succ_id_q;
		end else begin
			nxt_vld = 1'b1;
			nxt_id  = head_ent.id;
		end
	end

	// Sequencer next state and chain command.
	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		cmd.op    = mfs_pkg::CELL_HOLD;
		case (state_q)
			mfs_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (!tick) begin
						if (reg_ok) begin
							cmd.op    = mfs_pkg::CELL_APPEND;
							cmd.pos   = count_q;
							cmd.wdata = '{vld: 1'b1, id: in_id, lvl: mfs_pkg::TOP_LVL,
								allot: allot_cfg_q};
						end
						state_n = mfs_pkg::ST_DONE;
					end else if (boost_now) begin
						state_n = mfs_pkg::ST_BOOST_DEL;
					end else begin
						state_n = mfs_pkg::ST_CHARGE;
					end
				end
			end
			mfs_pkg::ST_BOOST_DEL: begin
				if (f_low.found) begin
					cmd.op  = mfs_pkg::CELL_REMOVE;
					cmd.pos = mfs_pkg::CNT_W'(f_low.idx);
				end else begin
					state_n = mfs_pkg::ST_BOOST_ADD;
				end
			end
			mfs_pkg::ST_BOOST_ADD: begin
				if (low_mask_q[add_id]) begin
					cmd.op    = mfs_pkg::CELL_APPEND;
					cmd.pos   = count_q;
					cmd.wdata = '{vld: 1'b1, id: add_id, lvl: mfs_pkg::TOP_LVL,
						allot: allot_cfg_q};
				end
				if (iter_q == 5'(mfs_pkg::ID_SPACE - 1)) state_n = mfs_pkg::ST_CHARGE;
			end
			mfs_pkg::ST_CHARGE: begin
				if (prev_vld_q) begin
					if (demote) begin
						cmd.op  = mfs_pkg::CELL_REMOVE;
						cmd.pos = mfs_pkg::CNT_W'(f_prev.idx);
						state_n = mfs_pkg::ST_DEMOTE_ADD;
					end else begin
						cmd.op    = mfs_pkg::CELL_UPDATE;
						cmd.pos   = mfs_pkg::CNT_W'(f_prev.idx);
						cmd.wdata = prev_ent;
						cmd.wdata.allot = a_new;
						state_n = mfs_pkg::ST_PICK;
					end
				end else begin
					state_n = mfs_pkg::ST_PICK;
				end
			end
			mfs_pkg::ST_DEMOTE_ADD: begin
				cmd.op    = mfs_pkg::CELL_APPEND;
				cmd.pos   = count_q;
				cmd.wdata = dem_q;
				state_n   = mfs_pkg::ST_PICK;
			end
			mfs_pkg::ST_PICK: begin
				state_n = mfs_pkg::ST_DONE;
			end
			mfs_pkg::ST_DONE: begin
				if (!out_vld_q || m_tready) state_n = mfs_pkg::ST_IDLE;
			end
			default: begin
				state_n = mfs_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mfs_pkg::ST_IDLE;
		else         state_q <= state_n;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allot_cfg_q <= 4'd2;
			period_q    <= 10'd10;
			run_q       <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				mfs_pkg::REG_ALLOT:  allot_cfg_q <= cfg_data[3:0];
				mfs_pkg::REG_PERIOD: period_q    <= cfg_data[9:0];
				mfs_pkg::REG_RUN:    run_q       <= cfg_data;
				default:             run_q       <= run_q;
			endcase
		end
	end

	// Scheduler control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			count_q    <= '0;
			cur_vld_q  <= 1'b0;
			cur_id_q   <= '0;
			te_q       <= '0;
			tsb_q      <= '0;
			prev_vld_q <= 1'b0;
			prev_q     <= '0;
			succ_vld_q <= 1'b0;
			succ_id_q  <= '0;
			succ_lvl_q <= '0;
			dem_q      <= '0;
			low_mask_q <= '0;
			start_q    <= '0;
			res_q      <= '0;
			out_q      <= '0;
			out_vld_q  <= 1'b0;
			iter_q     <= '0;
		end else begin
			if (cmd.op == mfs_pkg::CELL_APPEND) count_q <= count_q + 1'b1;
			if (cmd.op == mfs_pkg::CELL_REMOVE) count_q <= count_q - 1'b1;
			case (state_q)
				mfs_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (!tick) begin
							res_q <= '{finished: fin, boosted: 1'b0, run_task: '0,
								run_valid: 1'b0, stop_task: '0, stop_valid: 1'b0,
								register_ok: reg_ok};
							if (reg_ok) present_q[in_id] <= 1'b1;
						end else begin
							te_q       <= te_n;
							tsb_q      <= boost_now ? 11'd1 : tsb_n;
							res_q <= '{finished: 1'b0, boosted: boost_now, run_task: '0,
								run_valid: 1'b0, stop_task: cur_vld_q ? cur_id_q : '0,
								stop_valid: cur_vld_q, register_ok: 1'b0};
							prev_vld_q <= cur_vld_q;
							prev_q     <= cur_id_q;
							low_mask_q <= '0;
							start_q    <= '0;
							iter_q     <= '0;
						end
					end
				end
				mfs_pkg::ST_BOOST_DEL: begin
					if (f_low.found) begin
						low_mask_q[low_ent.id] <= 1'b1;
						if (prev_vld_q && low_ent.id == prev_q) start_q <= low_ent.id;
					end
				end
				mfs_pkg::ST_BOOST_ADD: begin
					iter_q <= iter_q + 5'd1;
				end
				mfs_pkg::ST_CHARGE: begin
					succ_vld_q <= prev_vld_q && f_succ.found;
					succ_id_q  <= succ_ent.id;
					succ_lvl_q <= succ_ent.lvl;
					dem_q <= '{vld: 1'b1, id: prev_q, lvl: prev_ent.lvl - 1'b1,
						allot: allot_cfg_q};
				end
				mfs_pkg::ST_PICK: begin
					res_q <= '{finished: fin, boosted: res_q.boosted,
						run_task: (nxt_vld && !fin) ? nxt_id : '0,
						run_valid: nxt_vld && !fin, stop_task: res_q.stop_task,
						stop_valid: res_q.stop_valid, register_ok: res_q.register_ok};
					if (nxt_vld && !fin) begin
						cur_vld_q       <= 1'b1;
						cur_id_q        <= nxt_id;
					end
				end
				default: begin
					iter_q <= iter_q;
				end
			endcase
			// Output register: takes a result when free or being drained.
			if (state_q == mfs_pkg::ST_DONE && (!out_vld_q || m_tready)) begin
				out_vld_q <= 1'b1;
				out_q     <= res_q;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_q};

	// Chain fill count agrees with the cell valid bits and, when idle, with the present mask.
	logic [MT-1:0] vld_vec;
	always_comb begin
		for (int i = 0; i < MT; i++) vld_vec[i] = ents[i].vld;
	end

	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == count_q)
		else $error("fill count differs from valid cells");

	a_count_present: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfs_pkg::ST_IDLE) |-> ($countones(present_q) == count_q))
		else $error("present mask differs from fill count");

	a_cur_present: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> present_q[cur_id_q])
		else $error("current task is not registered");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the multilevel feedback scheduler.
// Registrations and timer ticks go in as stream transfers; each result is compared with
// a model of the queues kept here. Depends on mfs_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_top;

	typedef struct packed {
		logic       kind;
		logic [3:0] task_id;
	} sched_item_t;

	typedef struct packed {
		logic       register_ok;
		logic       stop_valid;
		logic [3:0] stop_task;
		logic       run_valid;
		logic [3:0] run_task;
		logic       boosted;
		logic       finished;
	} sched_out_t;

	localparam logic KIND_REG  = 1'b0;
	localparam logic KIND_TICK = 1'b1;
	localparam int   CYCLE_LIMIT = 1500000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = mfs_pkg::REG_ALLOT;
	logic [15:0] cfg_data = '0;

	multilevel_feedback_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Scheduler state as predicted.
	int unsigned allot_cfg, period_cfg, run_cfg;
	bit          present [16];
	int unsigned lvl_of [16];
	int unsigned allot_of [16];
	int unsigned lvl_q [3][$];
	bit          cur_vld;
	int unsigned cur_task;
	int unsigned ticks_done, ticks_boost;

	sched_item_t pending_items [$];
	sched_out_t  expected_outs [$];
	int          errors = 0;
	bit          idle_free = 1'b0;
	bit          hold_src = 1'b0;
	int          accepted = 0;
	int          to_send = 0;

	function automatic int queue_pos(int unsigned lv, int unsigned id);
		for (int i = 0; i < lvl_q[lv].size(); i++)
			if (lvl_q[lv][i] == id) return i;
		return -1;
	endfunction

	function automatic int follower(int unsigned id);
		int p;
		p = queue_pos(lvl_of[id], id);
		if (p >= 0 && p + 1 < lvl_q[lvl_of[id]].size()) return lvl_q[lvl_of[id]][p + 1];
		return -1;
	endfunction

	function automatic int choose(int succ);
		int h;
		h = -1;
		for (int lv = 2; lv >= 0; lv--)
			if (h < 0 && lvl_q[lv].size() > 0) h = lv;
		if (succ < 0) return (h < 0) ? -1 : lvl_q[h][0];
		if (h < 0) return succ;
		return (lvl_of[succ] >= h) ? succ : lvl_q[h][0];
	endfunction

	// Lift all lower tasks to the top tail in id order, rotated to start at the current task.
	function automatic void lift_all();
		int unsigned ids [$];
		int k;
		k = 0;
		for (int id = 0; id < 16; id++)
			if (present[id] && lvl_of[id] < 2) ids.push_back(id);
		if (cur_vld && present[cur_task] && lvl_of[cur_task] < 2)
			foreach (ids[i])
				if (ids[i] == cur_task) k = i;
		lvl_q[0].delete();
		lvl_q[1].delete();
		for (int i = 0; i < ids.size(); i++) begin
			int unsigned t;
			t = ids[(k + i) % ids.size()];
			lvl_q[2].push_back(t);
			lvl_of[t] = 2;
			allot_of[t] = allot_cfg;
		end
	endfunction

	function automatic sched_out_t schedule_step(sched_item_t it);
		sched_out_t r;
		int nxt, total, p, succ_old;
		bit pv;
		int unsigned pt, a, lv;
		r = '0;
		if (it.kind == KIND_REG) begin
			total = 0;
			foreach (present[t]) total += present[t];
			if (!present[it.task_id] && total < mfs_pkg::MAX_TASKS) begin
				present[it.task_id] = 1'b1;
				lvl_of[it.task_id] = 2;
				allot_of[it.task_id] = allot_cfg;
				lvl_q[2].push_back(it.task_id);
				r.register_ok = 1'b1;
			end
			r.finished = ticks_done > run_cfg;
			return r;
		end
		if (ticks_done < 'h1FFFF) ticks_done++;
		if (ticks_boost < 'h7FF) ticks_boost++;
		pv = cur_vld;
		pt = cur_task;
		nxt = choose(pv ? follower(pt) : -1);
		if (ticks_boost >= period_cfg + 1) begin
			lift_all();
			ticks_boost = 1;
			r.boosted = 1'b1;
			nxt = choose(pv ? follower(pt) : -1);
		end
		if (pv) begin
			a = allot_of[pt];
			a = a ? a - 1 : 0;
			allot_of[pt] = a;
			if (a == 0 && lvl_of[pt] > 0) begin
				lv = lvl_of[pt];
				p = queue_pos(lv, pt);
				succ_old = -1;
				if (p >= 0) begin
					if (p + 1 < lvl_q[lv].size()) succ_old = lvl_q[lv][p + 1];
					lvl_q[lv].delete(p);
				end
				lvl_of[pt] = lv - 1;
				allot_of[pt] = allot_cfg;
				lvl_q[lv - 1].push_back(pt);
				nxt = choose(succ_old);
			end
		end
		if (ticks_done > run_cfg) begin
			nxt = -1;
			r.finished = 1'b1;
		end
		if (pv) begin
			r.stop_valid = 1'b1;
			r.stop_task = pt[3:0];
		end
		if (nxt >= 0) begin
			r.run_valid = 1'b1;
			r.run_task = nxt[3:0];
			cur_vld = 1'b1;
			cur_task = nxt;
		end
		return r;
	endfunction

	// Source driver: offers pending items, with random gaps unless told otherwise.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_outs.push_back(schedule_step(pending_items.pop_front()));
				accepted++;
			end
			if ((!s_tvalid || s_tready) || !s_tvalid) begin
				if (s_tvalid && !s_tready) begin
					// hold the current offer
				end else if (pending_items.size() > 0 && !hold_src
						&& (idle_free || $urandom_range(99) >= 34)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'd0, pending_items[0].task_id};
					s_tuser <= pending_items[0].kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random back-pressure and field-by-field comparison.
	always @(posedge clk) begin
		sched_out_t got, exp_out;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[0], m_tdata[1], m_tdata[5:2], m_tdata[6], m_tdata[10:7],
					m_tdata[11], m_tdata[12]};
				if (expected_outs.size() == 0) begin
					$error("unexpected result %h", m_tdata);
					errors++;
				end else begin
					exp_out = expected_outs.pop_front();
					if (got.register_ok !== exp_out.register_ok) begin
						$error("register_ok exp %0d got %0d", exp_out.register_ok, got.register_ok);
						errors++;
					end
					if (got.stop_valid !== exp_out.stop_valid) begin
						$error("stop_valid exp %0d got %0d", exp_out.stop_valid, got.stop_valid);
						errors++;
					end
					if (got.stop_task !== exp_out.stop_task) begin
						$error("stop_task exp %0d got %0d", exp_out.stop_task, got.stop_task);
						errors++;
					end
					if (got.run_valid !== exp_out.run_valid) begin
						$error("run_valid exp %0d got %0d", exp_out.run_valid, got.run_valid);
						errors++;
					end
					if (got.run_task !== exp_out.run_task) begin
						$error("run_task exp %0d got %0d", exp_out.run_task, got.run_task);
						errors++;
					end
					if (got.boosted !== exp_out.boosted) begin
						$error("boosted exp %0d got %0d", exp_out.boosted, got.boosted);
						errors++;
					end
					if (got.finished !== exp_out.finished) begin
						$error("finished exp %0d got %0d", exp_out.finished, got.finished);
						errors++;
					end
				end
			end
			m_tready <= idle_free || ($urandom_range(99) >= 34);
		end
	end

	// Run watchdog.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	task automatic wait_drained();
		while (accepted < to_send || expected_outs.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mfs_pkg::REG_ALLOT:  allot_cfg = val[3:0];
			mfs_pkg::REG_PERIOD: period_cfg = val[9:0];
			default:             run_cfg = val;
		endcase
	endtask

	task automatic add_item(logic kind, logic [3:0] id);
		pending_items.push_back('{kind, id});
		to_send++;
	endtask

	// One phase: a random mix of mostly ticks with occasional registrations, then a drain.
	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 22) add_item(KIND_REG, 4'($urandom_range(15)));
			else add_item(KIND_TICK, 4'($urandom_range(15)));
		end
		wait_drained();
	endtask

	initial begin
		allot_cfg = 2;
		period_cfg = 10;
		run_cfg = 100;
		foreach (present[i]) present[i] = 1'b0;
		cur_vld = 1'b0;
		cur_task = 0;
		ticks_done = 0;
		ticks_boost = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: tick on an empty scheduler, registrations incl. a duplicate, ticks.
		add_item(KIND_TICK, 4'hF);
		add_item(KIND_REG, 4'h0);
		add_item(KIND_REG, 4'hF);
		add_item(KIND_REG, 4'h0);
		add_item(KIND_REG, 4'h5);
		for (int i = 0; i < 14; i++) add_item(KIND_TICK, 4'h0);
		wait_drained();

		// Zero allotment and zero period: demotion and boost on every tick.
		write_reg(mfs_pkg::REG_ALLOT, 16'd0);
		write_reg(mfs_pkg::REG_PERIOD, 16'd0);
		write_reg(mfs_pkg::REG_RUN, 16'hFFFF);
		for (int id = 0; id < 16; id++) add_item(KIND_REG, id[3:0]);
		add_item(KIND_REG, 4'h3);
		for (int i = 0; i < 6; i++) add_item(KIND_TICK, 4'h0);
		wait_drained();

		// Sender holds back a pending tick while hold_src is set, then resumes.
		hold_src = 1'b1;
		add_item(KIND_TICK, 4'h0);
		repeat (20) @(posedge clk);
		hold_src = 1'b0;
		wait_drained();

		write_reg(mfs_pkg::REG_ALLOT, 16'd15);
		write_reg(mfs_pkg::REG_PERIOD, 16'd1023);
		random_phase(300);
		write_reg(mfs_pkg::REG_ALLOT, 16'd1);
		write_reg(mfs_pkg::REG_PERIOD, 16'd7);
		idle_free = 1'b1;
		random_phase(300);
		idle_free = 1'b0;
		write_reg(mfs_pkg::REG_ALLOT, 16'd3);
		write_reg(mfs_pkg::REG_PERIOD, 16'd1);
		random_phase(300);
		write_reg(mfs_pkg::REG_RUN, 16'd0);
		random_phase(60);
		write_reg(mfs_pkg::REG_ALLOT, 16'($urandom_range(1, 15)));
		write_reg(mfs_pkg::REG_PERIOD, 16'($urandom_range(1, 40)));
		write_reg(mfs_pkg::REG_RUN, 16'd1500);
		random_phase(700);

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
